### sv/swf_pkg.sv
// shared types, constants and helpers for the sample window framer
`default_nettype none
package swf_pkg;
	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int LEN_W = 7;
	localparam int PTR_W = 6;
	localparam int HOP_W = 5;
	localparam int DIV_CNT_W = 5;
	localparam int PROD_W = SAMPLE_BITS + LEN_W + 1;

	localparam logic [1:0] MODE_RECT = 2'd0;
	localparam logic [1:0] MODE_TRI = 2'd1;
	localparam logic [1:0] MODE_OVL = 2'd2;

	localparam logic REG_LEN = 1'b0;
	localparam logic REG_MODE = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_in;
		logic record_end;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic frame_end;
		logic run_last;
	} out_item_t;

	typedef struct packed {
		logic div_start;
		logic ring_wr;
		logic emit_ring;
		logic emit_pad;
		logic emit_direct;
		logic emit_div;
		logic frame_end;
		logic run_last;
		logic [PTR_W-1:0] ring_rd;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_busy;
		logic ring_pend;
	} dp_status_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] req);
		logic [LEN_W:0] l;
		begin
			l = {1'b0, req} + {{LEN_W{1'b0}}, req[0]};
			if (l < (LEN_W+1)'(4))
				l = (LEN_W+1)'(4);
			if (l > (LEN_W+1)'(WINDOW_MAX & ~1))
				l = (LEN_W+1)'(WINDOW_MAX & ~1);
			return l[LEN_W-1:0];
		end
	endfunction
endpackage
`default_nettype wire

### sv/swf_datapath.sv
// datapath: sample ring, triangular weight divider and output register
`default_nettype none
module swf_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire swf_pkg::in_item_t in_item,
	input wire logic [swf_pkg::LEN_W-1:0] len,
	input wire logic [swf_pkg::LEN_W-1:0] pos,
	input wire logic [swf_pkg::PTR_W-1:0] ring_head,
	input wire swf_pkg::dp_cmd_t cmd,
	output swf_pkg::dp_status_t status,
	output swf_pkg::out_item_t out_item,
	output logic out_valid,
	input wire logic out_stall
);
	import swf_pkg::*;

	logic signed [SAMPLE_BITS-1:0] ring_mem [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] ring_rd_q;
	logic [LEN_W-1:0] len_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [PROD_W-1:0] prod_q;
	logic prod_pend_q;
	logic neg_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic div_busy_q;
	logic div_done_q;
	logic [LEN_W-1:0] half;
	logic [LEN_W-1:0] gap;
	logic [LEN_W-1:0] weight;
	logic [SAMPLE_BITS-1:0] mag;
	logic [PROD_W:0] trial;
	logic [PROD_W-1:0] shifted;
	logic signed [SAMPLE_BITS-1:0] div_res;
	logic emit_any;
	logic hold_out;
	logic ring_pend_q;
	logic fe_q, rl_q;

	assign half = {1'b0, len[LEN_W-1:1]};
	assign gap = (pos >= half) ? (pos - half) : (half - pos);
	assign weight = len - {gap[LEN_W-2:0], 1'b0};
	assign mag = in_item.sample_in[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_item.sample_in)
		: SAMPLE_BITS'(in_item.sample_in);

	// restoring divide, one quotient bit a cycle over the weighted magnitude
	assign shifted = {rem_q[PROD_W-2:0], quo_q[PROD_W-1]};
	assign trial = {1'b0, shifted} - {{(PROD_W+1-LEN_W){1'b0}}, len_q};
	assign div_res = neg_q ? -SAMPLE_BITS'(quo_q) : SAMPLE_BITS'(quo_q);

	// ring read data and its flags are held until the item reaches the output
	always_ff @(posedge clk) begin
		if (cmd.ring_wr)
			ring_mem[ring_head] <= in_item.sample_in;
		if (cmd.emit_ring) begin
			ring_rd_q <= ring_mem[cmd.ring_rd];
			fe_q <= cmd.frame_end;
			rl_q <= cmd.run_last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			prod_q <= PROD_W'(mag) * PROD_W'(weight);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			cnt_q <= '0;
			neg_q <= 1'b0;
			len_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.div_start) begin
				div_busy_q <= 1'b0;
				cnt_q <= '0;
				neg_q <= in_item.sample_in[SAMPLE_BITS-1];
				len_q <= len;
			end else if (cnt_q == '0 && !div_busy_q && !div_done_q && prod_pend_q) begin
				div_busy_q <= 1'b1;
				rem_q <= '0;
				quo_q <= prod_q;
				cnt_q <= DIV_CNT_W'(PROD_W);
			end else if (div_busy_q) begin
				if (!trial[PROD_W]) begin
					rem_q <= trial[PROD_W-1:0];
					quo_q <= {quo_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[PROD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					div_busy_q <= 1'b0;
					div_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prod_pend_q <= 1'b0;
		else if (cmd.div_start)
			prod_pend_q <= 1'b1;
		else if (!div_busy_q && cnt_q == '0 && !div_done_q)
			prod_pend_q <= 1'b0;
	end

	assign hold_out = out_valid && out_stall;
	assign status = '{div_done: div_done_q, out_busy: hold_out, ring_pend: ring_pend_q};
	assign emit_any = cmd.emit_pad || cmd.emit_direct || cmd.emit_div;

	// ring read data is registered first, then moved to the output register once that is not held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_pend_q <= 1'b0;
			out_valid <= 1'b0;
			out_item <= '0;
		end else begin
			if (cmd.emit_ring)
				ring_pend_q <= 1'b1;
			else if (!hold_out)
				ring_pend_q <= 1'b0;
			if (ring_pend_q && !hold_out) begin
				out_valid <= 1'b1;
				out_item <= '{ring_rd_q, fe_q, rl_q};
			end else if (emit_any) begin
				out_valid <= 1'b1;
				out_item.sample_out <= cmd.emit_pad ? '0
					: (cmd.emit_div ? div_res : in_item.sample_in);
				out_item.frame_end <= cmd.frame_end;
				out_item.run_last <= cmd.run_last;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

### sv/swf_ctrl.sv
// controller: framing state, mode sequencing and output pacing
`default_nettype none
module swf_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire swf_pkg::in_item_t in_item,
	input wire logic cfg_we,
	input wire logic [swf_pkg::LEN_W-1:0] len,
	input wire logic [1:0] mode,
	input wire logic out_stall,
	input wire swf_pkg::dp_status_t status,
	output swf_pkg::dp_cmd_t cmd,
	output logic [swf_pkg::LEN_W-1:0] pos_out,
	output logic [swf_pkg::PTR_W-1:0] head_out
);
	import swf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV = 3'd1;
	localparam logic [2:0] ST_EMIT1 = 3'd2;
	localparam logic [2:0] ST_PAD = 3'd3;
	localparam logic [2:0] ST_RING = 3'd4;
	localparam logic [2:0] ST_DRAIN = 3'd5;

	logic [2:0] state_q;
	logic [LEN_W-1:0] pos_q;
	logic [LEN_W-1:0] seen_q;
	logic [HOP_W-1:0] hop_q;
	logic [PTR_W-1:0] head_q;
	logic [LEN_W-1:0] cnt_q;
	logic [PTR_W-1:0] rd_q;
	logic end_q;
	logic [LEN_W-1:0] p;
	logic [LEN_W-1:0] p_next;
	logic [HOP_W-1:0] hop;
	logic accept;
	logic out_free;
	logic frame_due;

	assign out_free = !status.out_busy;
	assign in_stall = (state_q != ST_IDLE) || !out_free || status.ring_pend;
	assign accept = in_valid && !in_stall;
	assign p = (pos_q >= len) ? '0 : pos_q;
	assign p_next = (p + 1'b1 >= len) ? '0 : p + 1'b1;
	assign hop = HOP_W'(len >> 2);
	assign frame_due = (seen_q < len) ? (seen_q + 1'b1 == len) : (hop_q + 1'b1 >= hop);
	assign pos_out = p;
	assign head_out = head_q;

	always_comb begin
		cmd = '0;
		cmd.ring_rd = rd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_OVL) begin
						cmd.ring_wr = 1'b1;
					end else if (mode == MODE_TRI) begin
						cmd.div_start = 1'b1;
					end else begin
						cmd.emit_direct = 1'b1;
						cmd.frame_end = (p == len - 1'b1);
						cmd.run_last = !(in_item.record_end && p_next != '0);
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					cmd.emit_div = 1'b1;
					cmd.frame_end = (cnt_q == len - 1'b1);
					cmd.run_last = !(end_q && pos_q != '0);
				end
			end
			ST_PAD: begin
				if (out_free) begin
					cmd.emit_pad = 1'b1;
					cmd.frame_end = (cnt_q == len - 1'b1);
					cmd.run_last = (cnt_q == len - 1'b1);
				end
			end
			ST_RING: begin
				if (out_free) begin
					cmd.emit_ring = 1'b1;
					cmd.frame_end = (cnt_q == len - 1'b1);
					cmd.run_last = (cnt_q == len - 1'b1);
				end
			end
			ST_EMIT1, ST_DRAIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			seen_q <= '0;
			hop_q <= '0;
			head_q <= '0;
			cnt_q <= '0;
			rd_q <= '0;
			end_q <= 1'b0;
		end else if (cfg_we) begin
			pos_q <= '0;
			seen_q <= '0;
			hop_q <= '0;
			head_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						end_q <= in_item.record_end;
						if (mode == MODE_OVL) begin
							head_q <= head_q + 1'b1;
							if (seen_q < len)
								seen_q <= seen_q + 1'b1;
							hop_q <= (seen_q < len) ? '0 : hop_q + 1'b1;
							if (frame_due) begin
								hop_q <= '0;
								state_q <= ST_RING;
								cnt_q <= '0;
								rd_q <= PTR_W'(head_q + 1'b1 - PTR_W'(len));
							end
							if (in_item.record_end) begin
								seen_q <= '0;
								hop_q <= '0;
								head_q <= '0;
							end
						end else if (mode == MODE_TRI) begin
							cnt_q <= p;
							pos_q <= in_item.record_end ? '0 : p_next;
							if (in_item.record_end)
								pos_q <= p_next;
							state_q <= ST_DIV;
						end else begin
							pos_q <= in_item.record_end ? '0 : p_next;
							if (in_item.record_end && p_next != '0) begin
								cnt_q <= p_next;
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						if (end_q && pos_q != '0) begin
							cnt_q <= pos_q;
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
						if (end_q)
							pos_q <= '0;
					end
				end
				ST_PAD: begin
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == len - 1'b1)
							state_q <= ST_IDLE;
					end
				end
				ST_RING: begin
					if (out_free) begin
						cnt_q <= cnt_q + 1'b1;
						rd_q <= rd_q + 1'b1;
						if (cnt_q == len - 1'b1)
							state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				ST_EMIT1: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### sv/sample_window_framer.sv
// top level of the sample window framer
//
// Cuts a stream of signed samples into frames of L samples (window_len rounded up to
// even, clamped to 4..64). Items come in on in_valid/in_stall, results leave on
// out_valid/out_stall; an item moves when valid is high and stall is low.
// Rectangular mode: one result per item, registered at the accepting edge, so an item
// can be taken every cycle while out_stall is low; a record end inside a frame is
// followed by zero padding, one result per cycle while out_stall is low.
// Triangular mode: the weighted sample goes through a bit-serial divider; the product is
// registered and run through the 24-bit restoring divide, the quotient is registered at
// the output, and no new item is taken until that result has been emitted.
// Overlap mode: items go into the ring; at the L-th item and every L/4 items after,
// the last L samples are read out one per cycle while out_stall is low; input waits.
// Configuration writes (cfg_index 0 length, 1 mode) restart framing and are taken
// at any time; write only while idle.
// Reset sets length 16, rectangular mode and clears all framing state; the ring
// contents are undefined until written.
// While out_stall holds, the block stops accepting input and emitting further results
// and the output register keeps its item, unless a triangular divide finishes then.
`default_nettype none
module sample_window_framer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire swf_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output swf_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [swf_pkg::LEN_W-1:0] cfg_data
);
	import swf_pkg::*;

	logic [LEN_W-1:0] len_req_q;
	logic [1:0] mode_q;
	logic cfg_we;
	logic [LEN_W-1:0] len;
	logic [LEN_W-1:0] pos;
	logic [PTR_W-1:0] head;
	dp_cmd_t cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;
	assign len = eff_len(len_req_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_req_q <= LEN_W'(16);
			mode_q <= MODE_RECT;
		end else if (cfg_we) begin
			unique case (cfg_index[0])
				REG_LEN: len_req_q <= cfg_data;
				REG_MODE: mode_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	swf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_data),
		.cfg_we(cfg_we), .len(len), .mode(mode_q),
		.out_stall(out_stall), .status(status), .cmd(cmd),
		.pos_out(pos), .head_out(head)
	);

	swf_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_item(in_data), .len(len), .pos(pos), .ring_head(head),
		.cmd(cmd), .status(status),
		.out_item(out_data), .out_valid(out_valid), .out_stall(out_stall)
	);
endmodule
`default_nettype wire
